// ===== rtl/radiotap_header_check_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radiotap header check core
// Concurrent assertions with a common clock and active-low reset, defined
// empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef RADIOTAP_HEADER_CHECK_CORE_ASSERT_SVH
`define RADIOTAP_HEADER_CHECK_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property holds at every edge outside reset
`define RTHC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rthc assertion failed");

// consequent holds in the cycle after the antecedent
`define RTHC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rthc assertion failed");

`else

`define RTHC_ASSERT(name, clk, rst_n, prop)
`define RTHC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rthc_pkg.sv =====
// ----------------------------------------------------------------------------
// rthc_pkg
// Types, constants and the field size table shared by the header check core.
// ----------------------------------------------------------------------------
`default_nettype none

package rthc_pkg;

  // bitmap bits that carry a size entry
  localparam int unsigned ELEMENT_COUNT = 18;
  // version, pad, length and present bitmap
  localparam int unsigned FIXED_HDR_BYTES = 8;
  // largest possible total of field bytes (sum of the table)
  localparam int unsigned FIELD_BYTES_MAX = 34;
  localparam int unsigned FB_W = 7;

  // byte offsets within the fixed header
  localparam logic [15:0] OFS_VERSION = 16'd0;
  localparam logic [15:0] OFS_LEN_LO  = 16'd2;
  localparam logic [15:0] OFS_LEN_HI  = 16'd3;
  localparam logic [15:0] OFS_PRESENT = 16'd4;
  localparam logic [15:0] IDX_MAX     = 16'hFFFF;

  // field size in bytes per bitmap bit
  localparam logic [3:0] FIELD_SIZE [0:31] = '{
    4'd8, 4'd1, 4'd1, 4'd4, 4'd2, 4'd1, 4'd1, 4'd2,
    4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
    4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  // header values of one finished frame, handed to the check stage
  typedef struct packed {
    logic            enable;
    logic [7:0]      version;
    logic [15:0]     hdr_len;
    logic [FB_W-1:0] field_bytes;
    logic [15:0]     frame_len;
    logic            rate_bit;
    logic [7:0]      rate;
  } snap_t;

  // size of one bitmap bit, zero past the table
  function automatic logic [3:0] field_size(input logic [4:0] bit_idx);
    logic [3:0] sz;
    sz = (int'(bit_idx) < int'(ELEMENT_COUNT)) ? FIELD_SIZE[bit_idx] : 4'd0;
    return sz;
  endfunction

  // field bytes contributed by one byte of the present bitmap
  function automatic logic [FB_W-1:0] byte_field_bytes(input logic [7:0] bits,
                                                       input logic [1:0] byte_sel);
    logic [FB_W-1:0] sum;
    logic [4:0]      bit_idx;
    sum = '0;
    for (int j = 0; j < 8; j++) begin
      bit_idx = {byte_sel, 3'(j)};
      if (bits[j]) begin
        sum = sum + FB_W'(field_size(bit_idx));
      end
    end
    return sum;
  endfunction

  // offset of the rate byte: after TSFT and flags when present
  function automatic logic [4:0] rate_offset(input logic [1:0] low_bits);
    logic [4:0] ofs;
    ofs = 5'(FIXED_HDR_BYTES);
    if (low_bits[0]) ofs = ofs + 5'(FIELD_SIZE[0]);
    if (low_bits[1]) ofs = ofs + 5'(FIELD_SIZE[1]);
    return ofs;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rthc_frame_track.sv =====
// ----------------------------------------------------------------------------
// rthc_frame_track
// Per-byte header capture: byte counter, version, length, bitmap, running
// field byte total and rate byte. Hands a snapshot to the check stage on the
// last byte of a frame and clears for the next one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radiotap_header_check_core_assert.svh"

module rthc_frame_track (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           enable_i,
  input  wire logic           byte_valid_i,
  output logic                byte_ready_o,
  input  wire logic [7:0]     byte_i,
  input  wire logic           last_i,
  output logic                snap_valid_o,
  input  wire logic           snap_ready_i,
  output rthc_pkg::snap_t     snap_o
);
  import rthc_pkg::*;

  logic [15:0]     idx_q, idx_d, idx_inc;
  logic [7:0]      ver_q, ver_d;
  logic [15:0]     len_q, len_d;
  logic [31:0]     pres_q, pres_d;
  logic [FB_W-1:0] fb_q, fb_d;
  logic [7:0]      rate_q, rate_d;
  logic            snap_valid_q, snap_valid_d;
  snap_t           snap_q, snap_d;
  logic            acc;
  logic            in_bitmap;

  assign byte_ready_o = !snap_valid_q || snap_ready_i;
  assign acc          = byte_valid_i && byte_ready_o;
  assign in_bitmap    = (idx_q >= OFS_PRESENT) && (idx_q < 16'(FIXED_HDR_BYTES));
  assign idx_inc      = (idx_q == IDX_MAX) ? idx_q : idx_q + 16'd1;

  // header fields updated by the current byte
  always_comb begin
    ver_d  = ver_q;
    len_d  = len_q;
    pres_d = pres_q;
    fb_d   = fb_q;
    rate_d = rate_q;
    if (idx_q == OFS_VERSION) begin
      ver_d = byte_i;
    end else if (idx_q == OFS_LEN_LO) begin
      len_d[7:0] = byte_i;
    end else if (idx_q == OFS_LEN_HI) begin
      len_d[15:8] = byte_i;
    end else if (in_bitmap) begin
      case (idx_q[1:0])
        2'd0:    pres_d[7:0]   = byte_i;
        2'd1:    pres_d[15:8]  = byte_i;
        2'd2:    pres_d[23:16] = byte_i;
        default: pres_d[31:24] = byte_i;
      endcase
      // each bitmap byte arrives once per frame, so the total accumulates
      fb_d = fb_q + byte_field_bytes(byte_i, idx_q[1:0]);
    end else if (idx_q >= 16'(FIXED_HDR_BYTES) &&
                 idx_q == 16'(rate_offset(pres_q[1:0]))) begin
      rate_d = byte_i;
    end
  end

  // snapshot of the finished frame
  always_comb begin
    snap_d.enable      = enable_i;
    snap_d.version     = ver_d;
    snap_d.hdr_len     = len_d;
    snap_d.field_bytes = fb_d;
    snap_d.frame_len   = idx_inc;
    snap_d.rate_bit    = pres_d[2];
    snap_d.rate        = rate_d;
  end

  always_comb begin
    snap_valid_d = snap_valid_q;
    if (acc && last_i) begin
      snap_valid_d = 1'b1;
    end else if (snap_ready_i) begin
      snap_valid_d = 1'b0;
    end
  end

  // frame state: advance on each byte, clear after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ver_q  <= '0;
      len_q  <= '0;
      pres_q <= '0;
      fb_q   <= '0;
      rate_q <= '0;
    end else if (acc) begin
      if (last_i) begin
        idx_q  <= '0;
        ver_q  <= '0;
        len_q  <= '0;
        pres_q <= '0;
        fb_q   <= '0;
        rate_q <= '0;
      end else begin
        idx_q  <= idx_inc;
        ver_q  <= ver_d;
        len_q  <= len_d;
        pres_q <= pres_d;
        fb_q   <= fb_d;
        rate_q <= rate_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && last_i) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  `RTHC_ASSERT_NEXT(a_last_gives_snap, clk_i, rst_ni, acc && last_i, snap_valid_q)
  `RTHC_ASSERT_NEXT(a_last_clears_idx, clk_i, rst_ni, acc && last_i, idx_q == '0)
  `RTHC_ASSERT(a_fb_bound, clk_i, rst_ni, fb_q <= FB_W'(FIELD_BYTES_MAX))

endmodule

`default_nettype wire

// ===== rtl/rthc_check.sv =====
// ----------------------------------------------------------------------------
// rthc_check
// Validity checks on a frame snapshot and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radiotap_header_check_core_assert.svh"

module rthc_check (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           snap_valid_i,
  output logic                snap_ready_o,
  input  wire rthc_pkg::snap_t snap_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output logic                header_ok_o,
  output logic                rate_found_o,
  output logic [7:0]          rate_value_o,
  output logic [15:0]         strip_length_o
);
  import rthc_pkg::*;

  logic        valid_q, valid_d;
  logic        ok_q, ok_d;
  logic        rate_ok_q, rate_ok_d;
  logic [7:0]  rate_q, rate_d;
  logic [15:0] strip_q, strip_d;
  logic [16:0] min_len;
  logic        load;

  assign snap_ready_o = !valid_q || res_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  // enable, version and length checks
  assign min_len = 17'(FIXED_HDR_BYTES) + 17'(snap_i.field_bytes);
  always_comb begin
    ok_d = snap_i.enable
        && (snap_i.frame_len >= 16'(FIXED_HDR_BYTES))
        && (snap_i.version == 8'd0)
        && ({1'b0, snap_i.hdr_len} >= min_len)
        && (snap_i.hdr_len <= snap_i.frame_len);
    rate_ok_d = ok_d && snap_i.rate_bit;
    rate_d    = rate_ok_d ? snap_i.rate : 8'd0;
    strip_d   = ok_d ? snap_i.hdr_len : 16'd0;
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (res_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q      <= ok_d;
      rate_ok_q <= rate_ok_d;
      rate_q    <= rate_d;
      strip_q   <= strip_d;
    end
  end

  assign res_valid_o    = valid_q;
  assign header_ok_o    = ok_q;
  assign rate_found_o   = rate_ok_q;
  assign rate_value_o   = rate_q;
  assign strip_length_o = strip_q;

  `RTHC_ASSERT(a_rate_needs_ok, clk_i, rst_ni, !valid_q || ok_q || !rate_ok_q)
  `RTHC_ASSERT(a_bad_no_strip, clk_i, rst_ni, !valid_q || ok_q || strip_q == 16'd0)
  `RTHC_ASSERT(a_ok_min_strip, clk_i, rst_ni,
    !valid_q || !ok_q || strip_q >= 16'(FIXED_HDR_BYTES))

endmodule

`default_nettype wire

// ===== rtl/radiotap_header_check_core.sv =====
// ----------------------------------------------------------------------------
// radiotap_header_check_core
// Checks the radiotap header at the front of a transmit frame, captures the
// rate byte and reports the number of header bytes to strip.
//
//   channel   dir  sync          contents
//   s_axis    in   tvalid/tready tdata[7:0] frame byte, tlast end of frame
//   m_axis    out  tvalid/tready one result per frame
//   cfg       in   valid/ready   radiotap enable bit
//
// One byte is taken per cycle unless s_axis is stalled; the byte counter
// and capture registers update in the transfer cycle. After the last byte of
// a frame the snapshot register loads, then the check result register.
// Back-pressure on m_axis stalls s_axis only once both the result register
// and the snapshot register are full. Reset clears all control state and
// the enable bit; no clearing pass is needed. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module radiotap_header_check_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,      // [0] radiotap_enable
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o   // [0] header_ok, [1] rate_found,
                                            // [9:2] rate_value,
                                            // [25:10] strip_length, [31:26] 0
);
  import rthc_pkg::*;

  logic        enable_q;
  logic        snap_valid;
  logic        snap_ready;
  snap_t       snap;
  logic        header_ok;
  logic        rate_found;
  logic [7:0]  rate_value;
  logic [15:0] strip_length;

  // enable register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      enable_q <= cfg_data_i;
    end
  end

  rthc_frame_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  rthc_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_valid_i   (snap_valid),
    .snap_ready_o   (snap_ready),
    .snap_i         (snap),
    .res_valid_o    (m_axis_tvalid_o),
    .res_ready_i    (m_axis_tready_i),
    .header_ok_o    (header_ok),
    .rate_found_o   (rate_found),
    .rate_value_o   (rate_value),
    .strip_length_o (strip_length)
  );

  // result packing, first field in the lowest bit
  assign m_axis_tdata_o = {6'd0, strip_length, rate_value, rate_found, header_ok};

endmodule

`default_nettype wire
